// ----- design/lr_pkg.sv -----
// lr_pkg: shared codes for the line rasterizer
// command codes, axis step directions and the colour width; no dependencies
package lr_pkg;

    localparam int COLOR_BITS = 16;

    // input command codes
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd_code;

    // per-axis step direction
    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } t_dir;

endpackage

// ----- design/line_rasterizer_core.sv -----
// line_rasterizer_core: top level of the line rasterizer
// instantiates lr_front, lr_queue and lr_back; uses lr_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready) carries command words: a start
//   word loads both endpoints and a colour and emits the first pixel, an
//   advance word emits the next pixel of the active line. an advance word
//   with no active line is consumed and gives no pixel.
//   output channel (o_out_valid / i_out_ready) carries one pixel word per
//   producing command: coordinates, colour and a last-pixel flag.
//   a line from (x0,y0) to (x1,y1) gives max(|dx|,|dy|)+1 pixels.
// timing
//   a pixel word is registered after its command word leaves the queue.
//   rate is one word per clock while the receiver is ready, set by the
//   walker step (one add, one compare and one subtract per axis); front
//   setup (subtracts and a max) runs in parallel via a two-entry queue.
// reset and stalls
//   synchronous active-low reset empties the queue, drops the active line
//   and clears the output valid flag. when the receiver stalls, the pixel
//   word holds in the output register, the walker stops, and the queue
//   keeps taking words until full, after which o_in_ready drops.
module line_rasterizer_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_line_color,
    // pixel channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_last_pixel
);

    // setup word: start flag, two directions, five coordinates, colour
    localparam int CMD_W       = 5 * COORD_BITS + 5 + COLOR_BITS;
    localparam int QUEUE_DEPTH = 2;

    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queue_cmd;
    logic             queue_full;
    logic             queue_valid;
    logic             push;
    logic             pop;

    // word accepted into the queue straight from the ports
    assign o_in_ready = !queue_full;
    assign push       = i_in_valid && o_in_ready;

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_command    (i_command),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .o_cmd        (front_cmd)
    );

    lr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    // walker pops one setup word per clock while the output register frees
    lr_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (queue_valid),
        .i_cmd         (queue_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    // walker never pops an empty queue
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> queue_valid)
        else $error("walker popped an empty queue");

    // a fresh pixel word always comes from a word popped the cycle before
    a_pixel_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("pixel word appeared without a popped command");

    // reset leaves no pixel word pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ----- design/lr_front.sv -----
// lr_front: classifies an incoming word and precomputes the line setup
// (absolute deltas, step directions, major length); uses lr_pkg
module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int CMD_W      = 5 * COORD_BITS + 5 + COLOR_BITS
) (
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0] i_line_color,
    output logic [CMD_W-1:0]      o_cmd
);

    typedef struct packed {
        logic                  start;
        t_dir                  dir_x;
        t_dir                  dir_y;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] adx;
        logic [COORD_BITS-1:0] ady;
        logic [COORD_BITS-1:0] major;
        logic [COLOR_BITS-1:0] color;
    } t_line_cmd;

    t_line_cmd cmd;

    always_comb begin
        cmd       = '0;
        cmd.start = (t_cmd_code'(i_command) == CMD_START);
        cmd.sx    = i_start_x;
        cmd.sy    = i_start_y;
        cmd.color = i_line_color;

        if (i_end_x > i_start_x) begin
            cmd.adx   = i_end_x - i_start_x;
            cmd.dir_x = DIR_PLUS;
        end else if (i_end_x == i_start_x) begin
            cmd.adx   = '0;
            cmd.dir_x = DIR_NONE;
        end else begin
            cmd.adx   = i_start_x - i_end_x;
            cmd.dir_x = DIR_MINUS;
        end

        if (i_end_y > i_start_y) begin
            cmd.ady   = i_end_y - i_start_y;
            cmd.dir_y = DIR_PLUS;
        end else if (i_end_y == i_start_y) begin
            cmd.ady   = '0;
            cmd.dir_y = DIR_NONE;
        end else begin
            cmd.ady   = i_start_y - i_end_y;
            cmd.dir_y = DIR_MINUS;
        end

        cmd.major = (cmd.adx > cmd.ady) ? cmd.adx : cmd.ady;
    end

    assign o_cmd = cmd;

endmodule

// ----- design/lr_queue.sv -----
// lr_queue: small register fifo between the front and the walker
// generic width and depth; no package dependencies
module lr_queue #(
    parameter int WIDTH = 71,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/lr_back.sv -----
// lr_back: line walker with error accumulation and the output register
// takes setup words from lr_queue; uses lr_pkg
module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int CMD_W      = 5 * COORD_BITS + 5 + COLOR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  logic [CMD_W-1:0]      i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0] o_pixel_color,
    output logic                  o_last_pixel
);

    typedef struct packed {
        logic                  start;
        t_dir                  dir_x;
        t_dir                  dir_y;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] adx;
        logic [COORD_BITS-1:0] ady;
        logic [COORD_BITS-1:0] major;
        logic [COLOR_BITS-1:0] color;
    } t_line_cmd;

    t_line_cmd cmd;
    assign cmd = i_cmd;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS:0]   r_err_x, n_err_x;
    logic [COORD_BITS:0]   r_err_y, n_err_y;
    logic [COORD_BITS-1:0] r_abs_dx, r_abs_dy, r_major;
    t_dir                  r_dir_x, r_dir_y;
    logic [COORD_BITS:0]   r_pixels_left, n_pixels_left;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_active, n_active;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_pix_x, r_pix_y;
    logic [COLOR_BITS-1:0] r_pix_color;
    logic                  r_pix_last;

    // effective state for this step
    logic [COORD_BITS-1:0] e_x, e_y, e_adx, e_ady, e_major;
    logic [COORD_BITS:0]   e_err_x, e_err_y, e_pl;
    t_dir                  e_dir_x, e_dir_y;
    logic [COLOR_BITS-1:0] e_color;
    logic [COORD_BITS:0]   sum_x, sum_y;
    logic                  last;
    logic                  produce;

    function automatic logic [COORD_BITS-1:0] move_coord(
        input logic [COORD_BITS-1:0] c,
        input t_dir                  d
    );
        logic [COORD_BITS-1:0] r;
        case (d)
            DIR_PLUS:  r = c + 1'b1;
            DIR_MINUS: r = c - 1'b1;
            default:   r = c;
        endcase
        return r;
    endfunction

    assign o_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign produce = o_pop && (cmd.start || r_active);

    always_comb begin
        if (cmd.start) begin
            e_x     = cmd.sx;
            e_y     = cmd.sy;
            e_adx   = cmd.adx;
            e_ady   = cmd.ady;
            e_major = cmd.major;
            e_dir_x = cmd.dir_x;
            e_dir_y = cmd.dir_y;
            e_color = cmd.color;
            e_err_x = '0;
            e_err_y = '0;
            e_pl    = {1'b0, cmd.major} + 1'b1;
        end else begin
            e_x     = r_cur_x;
            e_y     = r_cur_y;
            e_adx   = r_abs_dx;
            e_ady   = r_abs_dy;
            e_major = r_major;
            e_dir_x = r_dir_x;
            e_dir_y = r_dir_y;
            e_color = r_color;
            e_err_x = r_err_x;
            e_err_y = r_err_y;
            e_pl    = r_pixels_left;
        end

        n_pixels_left = (e_pl != '0) ? e_pl - 1'b1 : e_pl;
        last          = (n_pixels_left == '0);
        n_active      = !last;

        // error stays at or below major length, so the sum fits
        sum_x = e_err_x + {1'b0, e_adx};
        sum_y = e_err_y + {1'b0, e_ady};
        if (sum_x > {1'b0, e_major}) begin
            n_err_x = sum_x - {1'b0, e_major};
            n_cur_x = move_coord(e_x, e_dir_x);
        end else begin
            n_err_x = sum_x;
            n_cur_x = e_x;
        end
        if (sum_y > {1'b0, e_major}) begin
            n_err_y = sum_y - {1'b0, e_major};
            n_cur_y = move_coord(e_y, e_dir_y);
        end else begin
            n_err_y = sum_y;
            n_cur_y = e_y;
        end

        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (produce) begin
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_err_x       <= n_err_x;
            r_err_y       <= n_err_y;
            r_abs_dx      <= e_adx;
            r_abs_dy      <= e_ady;
            r_major       <= e_major;
            r_dir_x       <= e_dir_x;
            r_dir_y       <= e_dir_y;
            r_color       <= e_color;
            r_pixels_left <= n_pixels_left;
            r_pix_x       <= e_x;
            r_pix_y       <= e_y;
            r_pix_color   <= e_color;
            r_pix_last    <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_pixel_color = r_pix_color;
    assign o_last_pixel  = r_pix_last;

endmodule
